// File: hw/rtl/rrt_pkg.sv
`default_nettype none

package rrt_pkg;

  // Architectural register file size and field widths.
  localparam int ArchRegs = 32;
  localparam int ArchW    = 5;
  localparam int TagW     = 6;
  localparam int FuncW    = 3;

  // Operation codes.
  typedef enum logic [FuncW-1:0] {
    FUNC_RENAME   = 3'd0,
    FUNC_COMPLETE = 3'd1,
    FUNC_RETIRE   = 3'd2,
    FUNC_UNDO     = 3'd3,
    FUNC_QUERY    = 3'd4
  } func_e;

  // One request transaction.
  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ArchW-1:0] src_a_reg;
    logic             src_a_used;
    logic [ArchW-1:0] src_b_reg;
    logic             src_b_used;
    logic [ArchW-1:0] dest_reg;
    logic             dest_used;
    logic [TagW-1:0]  tag_a;
    logic             tag_a_used;
    logic [TagW-1:0]  tag_b;
    logic             tag_b_used;
  } req_t;

  // One response transaction.
  typedef struct packed {
    logic [TagW-1:0] src_a_tag;
    logic [TagW-1:0] src_b_tag;
    logic [TagW-1:0] dest_tag;
    logic [TagW-1:0] prev_dest_tag;
    logic            dest_allocated;
    logic            alloc_failed;
    logic            ready_a;
    logic            ready_b;
  } rsp_t;

  // Pending alias table write, kept for forwarding to the next lookup.
  typedef struct packed {
    logic             valid;
    logic [ArchW-1:0] addr;
    logic [TagW-1:0]  data;
  } map_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/rrt_req_if.sv
`default_nettype none

interface rrt_req_if;
  import rrt_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rrt_rsp_if.sv
`default_nettype none

interface rrt_rsp_if;
  import rrt_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/register_rename_table_unit.sv
// Requests pass the stage-one register, then the output register; throughput is one request
// per cycle while responses are taken. The alias table is read in the accept cycle and the
// lowest free tag comes from a combinational priority encoder over the in-use vector.
// Reset (asynchronous, active low) restores the identity map and marks the first 32 tags
// in use and ready; the alias table memory needs no clearing pass.
`default_nettype none

module register_rename_table_unit #(
  parameter int PHYS_REGS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  rrt_req_if.sink     in_i,
  rrt_rsp_if.source   out_o
);
  import rrt_pkg::*;

  // Tags are 6 bits wide, so no tag above 63 is ever reachable.
  localparam int TagLimit = (PHYS_REGS < (1 << TagW)) ? PHYS_REGS : (1 << TagW);
  localparam logic [TagW:0] TagLimitV = (TagW + 1)'(TagLimit);
  localparam logic [TagLimit-1:0] ResetMask =
    {{(TagLimit - ArchRegs){1'b0}}, {ArchRegs{1'b1}}};

  // Handshake control.
  logic s1_valid_q;
  logic out_valid_q;
  logic fire;
  logic in_fire;

  // Stage registers.
  req_t    s1_q;
  rsp_t    out_q;
  rsp_t    out_d;
  map_wr_t byp_q;
  map_wr_t map_wr;

  // Alias table copies and their registered read data.
  logic [TagW-1:0] map_a_mem [ArchRegs];
  logic [TagW-1:0] map_b_mem [ArchRegs];
  logic [TagW-1:0] rd_sa_q;
  logic [TagW-1:0] rd_sb_q;
  logic [TagW-1:0] rd_dr_q;
  logic [ArchRegs-1:0] written_q;

  // Tag state vectors.
  logic [TagLimit-1:0] in_use_q;
  logic [TagLimit-1:0] in_use_d;
  logic [TagLimit-1:0] ready_q;
  logic [TagLimit-1:0] ready_d;

  // Resolved lookups and allocation.
  logic [TagW-1:0] map_sa;
  logic [TagW-1:0] map_sb;
  logic [TagW-1:0] map_dr;
  logic            free_found;
  logic [TagW-1:0] free_idx;

  assign fire      = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || fire;
  assign in_fire   = in_i.valid && in_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Alias table entry as seen by the item in stage one.
  function automatic logic [TagW-1:0] map_lookup(
    input logic [ArchW-1:0]    addr,
    input logic [TagW-1:0]     mem_data,
    input map_wr_t             byp,
    input logic [ArchRegs-1:0] written
  );
    logic [TagW-1:0] res;
    if (byp.valid && byp.addr == addr) begin
      res = byp.data;
    end else if (written[addr]) begin
      res = mem_data;
    end else begin
      res = {1'b0, addr};
    end
    return res;
  endfunction

  function automatic logic tag_ok(input logic [TagW-1:0] t);
    return {1'b0, t} < TagLimitV;
  endfunction

  assign map_sa = map_lookup(s1_q.src_a_reg, rd_sa_q, byp_q, written_q);
  assign map_sb = map_lookup(s1_q.src_b_reg, rd_sb_q, byp_q, written_q);
  assign map_dr = map_lookup(s1_q.dest_reg, rd_dr_q, byp_q, written_q);

  // Lowest free tag.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TagLimit - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = TagW'(i);
      end
    end
  end

  // Execute the item in stage one: response, vector updates and alias table write.
  always_comb begin
    logic dest_ok;
    dest_ok  = s1_q.dest_used && (s1_q.dest_reg != '0);
    out_d    = '0;
    in_use_d = in_use_q;
    ready_d  = ready_q;
    map_wr   = '0;
    map_wr.addr = s1_q.dest_reg;
    case (s1_q.func)
      FUNC_RENAME: begin
        if (s1_q.src_a_used) begin
          out_d.src_a_tag = map_sa;
          out_d.ready_a   = tag_ok(map_sa) ? ready_q[map_sa] : 1'b0;
        end else begin
          out_d.ready_a   = 1'b1;
        end
        if (s1_q.src_b_used) begin
          out_d.src_b_tag = map_sb;
          out_d.ready_b   = tag_ok(map_sb) ? ready_q[map_sb] : 1'b0;
        end else begin
          out_d.ready_b   = 1'b1;
        end
        if (dest_ok) begin
          if (!free_found) begin
            out_d.alloc_failed = 1'b1;
          end else begin
            out_d.prev_dest_tag  = map_dr;
            out_d.dest_tag       = free_idx;
            out_d.dest_allocated = 1'b1;
            in_use_d[free_idx]   = 1'b1;
            ready_d[free_idx]    = 1'b0;
            map_wr.valid         = 1'b1;
            map_wr.data          = free_idx;
          end
        end
      end
      FUNC_COMPLETE: begin
        if (s1_q.tag_a_used && tag_ok(s1_q.tag_a)) begin
          ready_d[s1_q.tag_a] = 1'b1;
        end
      end
      FUNC_RETIRE: begin
        if (s1_q.tag_a_used && tag_ok(s1_q.tag_a)) begin
          in_use_d[s1_q.tag_a] = 1'b0;
        end
      end
      FUNC_UNDO: begin
        if (dest_ok) begin
          if (s1_q.tag_b_used) begin
            map_wr.valid = 1'b1;
            map_wr.data  = s1_q.tag_b;
          end
          if (s1_q.tag_a_used && tag_ok(s1_q.tag_a)) begin
            in_use_d[s1_q.tag_a] = 1'b0;
          end
        end
      end
      FUNC_QUERY: begin
        out_d.ready_a = s1_q.tag_a_used ?
                        (tag_ok(s1_q.tag_a) ? ready_q[s1_q.tag_a] : 1'b0) : 1'b1;
        out_d.ready_b = s1_q.tag_b_used ?
                        (tag_ok(s1_q.tag_b) ? ready_q[s1_q.tag_b] : 1'b0) : 1'b1;
      end
      default: begin
        out_d = '0;
      end
    endcase
    if (!fire) begin
      map_wr.valid = 1'b0;
    end
  end

  // Alias table memories: written by the executing item, read at accept.
  always_ff @(posedge clk_i) begin
    if (map_wr.valid) begin
      map_a_mem[map_wr.addr] <= map_wr.data;
    end
    if (in_fire) begin
      rd_sa_q <= map_a_mem[in_i.data.src_a_reg];
      rd_dr_q <= map_a_mem[in_i.data.dest_reg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_wr.valid) begin
      map_b_mem[map_wr.addr] <= map_wr.data;
    end
    if (in_fire) begin
      rd_sb_q <= map_b_mem[in_i.data.src_b_reg];
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_i.data;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  // Control state, tag vectors and forwarding register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      in_use_q    <= ResetMask;
      ready_q     <= ResetMask;
      written_q   <= '0;
      byp_q       <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        byp_q      <= map_wr;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        in_use_q <= in_use_d;
        ready_q  <= ready_d;
      end
      if (map_wr.valid) begin
        written_q[map_wr.addr] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
